// File: hw/rtl/proximity_skin_min_tracker_core_assert.svh
// Assertion macros shared by the proximity skin minimum tracker RTL.
`ifndef PROXIMITY_SKIN_MIN_TRACKER_CORE_ASSERT_SVH
`define PROXIMITY_SKIN_MIN_TRACKER_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PSKIN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pskin assertion failed in the same cycle");

// Checks that the consequent holds in the cycle after the antecedent.
`define PSKIN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pskin assertion failed one cycle later");

`endif

// File: hw/rtl/pskin_pkg.sv
// Types and constants shared by the proximity skin minimum tracker modules.
`default_nettype none

package pskin_pkg;

    localparam int DIST_W       = 16;
    localparam int CODE_W       = 3;
    localparam int POS_W        = 3;
    localparam int SLOT_W       = 2;
    localparam int LOC_W        = SLOT_W + POS_W;
    localparam int LANE_COUNT   = 8;
    localparam int SLOT_COUNT   = 3;
    localparam int WINDOW_LEN_DEFAULT = 15;

    localparam logic [DIST_W-1:0] MAX_DISTANCE_RESET = 16'd1000;

    // Strip codes that own a slot.
    localparam logic [CODE_W-1:0] STRIP_SLOT0 = 3'd2;
    localparam logic [CODE_W-1:0] STRIP_SLOT1 = 3'd1;
    localparam logic [CODE_W-1:0] STRIP_SLOT2 = 3'd0;

    typedef struct packed {
        logic [CODE_W-1:0] strip_code;
        logic [DIST_W-1:0] dist_0;
        logic [DIST_W-1:0] dist_1;
        logic [DIST_W-1:0] dist_2;
        logic [DIST_W-1:0] dist_3;
        logic [DIST_W-1:0] dist_4;
        logic [DIST_W-1:0] dist_5;
        logic [DIST_W-1:0] dist_6;
        logic [DIST_W-1:0] dist_7;
    } in_beat_t;

    typedef struct packed {
        logic [DIST_W-1:0] avg_min_distance;
        logic [LOC_W-1:0]  min_location;
    } out_beat_t;

    // Overall minimum across the slots and where it sits.
    typedef struct packed {
        logic [DIST_W-1:0] min_dist;
        logic [LOC_W-1:0]  location;
    } best_t;

endpackage

`default_nettype wire

// File: hw/rtl/proximity_skin_min_tracker_core.sv
// Path: lane registers, slot registers, best_reg, loc_reg with the ring total, then out_reg (m_valid).
// Throughput: one beat per cycle unless m_ready stalls the output; each stage holds one beat
// and moves on when the next is free; slot minimum and window total update in separate stages.
// Reset (aresetn low, synchronous) empties the pipeline, zeroes slots and window, sets
// the clamp to 1000; window entries are tracked by valid bits, so no clearing pass is needed.
`default_nettype none

`include "proximity_skin_min_tracker_core_assert.svh"

module proximity_skin_min_tracker_core #(
    parameter int WINDOW_LEN = pskin_pkg::WINDOW_LEN_DEFAULT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [pskin_pkg::DIST_W-1:0] cfg_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire pskin_pkg::in_beat_t          s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output pskin_pkg::out_beat_t              m_data
);
    import pskin_pkg::*;

    logic [DIST_W-1:0] max_distance_reg;
    logic              stg1_vld_reg;
    logic              stg2_vld_reg;
    logic              stg3_vld_reg;
    logic              stg4_vld_reg;
    logic              out_vld_reg;
    logic [CODE_W-1:0] code_reg;
    best_t             best_reg;
    logic [LOC_W-1:0]  loc_reg;
    out_beat_t         out_reg;

    logic              move1, move2, move3, move4, move5;
    logic              free1, free2, free3, free4, free5;
    logic [DIST_W-1:0] raw_dist [LANE_COUNT];
    logic [DIST_W-1:0] lane_val [LANE_COUNT];
    best_t             best_now;
    logic [DIST_W-1:0] avg_now;

    // Configuration register; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_distance_reg <= MAX_DISTANCE_RESET;
        end else if (cfg_valid) begin
            max_distance_reg <= cfg_data;
        end
    end

    // A stage is free when empty or when its beat moves on this cycle.
    assign free5 = !out_vld_reg || m_ready;
    assign move5 = stg4_vld_reg && free5;
    assign free4 = !stg4_vld_reg || free5;
    assign move4 = stg3_vld_reg && free4;
    assign free3 = !stg3_vld_reg || free4;
    assign move3 = stg2_vld_reg && free3;
    assign free2 = !stg2_vld_reg || free3;
    assign move2 = stg1_vld_reg && free2;
    assign free1 = !stg1_vld_reg || free2;
    assign move1 = s_valid && free1;
    assign s_ready = free1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg1_vld_reg <= 1'b0;
            stg2_vld_reg <= 1'b0;
            stg3_vld_reg <= 1'b0;
            stg4_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (free1) stg1_vld_reg <= move1;
            if (free2) stg2_vld_reg <= move2;
            if (free3) stg3_vld_reg <= move3;
            if (free4) stg4_vld_reg <= move4;
            if (free5) out_vld_reg  <= move5;
        end
    end

    // Sensor order d0,d7,d1,d6,d2,d5,d3,d4 across the lanes.
    assign raw_dist[0] = s_data.dist_0;
    assign raw_dist[1] = s_data.dist_7;
    assign raw_dist[2] = s_data.dist_1;
    assign raw_dist[3] = s_data.dist_6;
    assign raw_dist[4] = s_data.dist_2;
    assign raw_dist[5] = s_data.dist_5;
    assign raw_dist[6] = s_data.dist_3;
    assign raw_dist[7] = s_data.dist_4;

    for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
        pskin_lane u_lane (
            .aclk         (aclk),
            .load         (move1),
            .dist_in      (raw_dist[g]),
            .max_distance (max_distance_reg),
            .clamped      (lane_val[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (move1) begin
            code_reg <= s_data.strip_code;
        end
    end

    // Slot update happens as the beat leaves the lane stage.
    pskin_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .upd_en     (move2),
        .strip_code (code_reg),
        .lane_val   (lane_val),
        .best       (best_now)
    );

    // Capture the overall minimum once the slots reflect this beat.
    always_ff @(posedge aclk) begin
        if (move3) begin
            best_reg <= best_now;
        end
        if (move4) begin
            loc_reg <= best_reg.location;
        end
        if (move5) begin
            out_reg.avg_min_distance <= avg_now;
            out_reg.min_location     <= loc_reg;
        end
    end

    pskin_ring #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (move4),
        .din     (best_reg.min_dist),
        .avg     (avg_now)
    );

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    // The input side stalls only when every stage holds a beat.
    `PSKIN_ASSERT_NOW(a_stall_only_when_full, !s_ready,
        stg1_vld_reg && stg2_vld_reg && stg3_vld_reg && stg4_vld_reg && out_vld_reg)
    // A finished total reaches an empty output register in the next cycle.
    `PSKIN_ASSERT_NEXT(a_output_fills, stg4_vld_reg && !out_vld_reg, out_vld_reg)
    // Only three slots exist, so the slot part of the location never reads three.
    `PSKIN_ASSERT_NOW(a_slot_in_range, m_valid, m_data.min_location[LOC_W-1:POS_W] != 2'd3)

endmodule

`default_nettype wire

// File: hw/rtl/pskin_lane.sv
// One distance lane: clamps a distance to the configured maximum and registers it.
`default_nettype none

module pskin_lane (
    input  wire logic                       aclk,
    input  wire logic                       load,
    input  wire logic [pskin_pkg::DIST_W-1:0] dist_in,
    input  wire logic [pskin_pkg::DIST_W-1:0] max_distance,
    output logic      [pskin_pkg::DIST_W-1:0] clamped
);
    import pskin_pkg::*;

    logic [DIST_W-1:0] clamped_reg;
    logic [DIST_W-1:0] clamped_next;

    // Saturate at the configured maximum.
    assign clamped_next = (dist_in > max_distance) ? max_distance : dist_in;

    always_ff @(posedge aclk) begin
        if (load) begin
            clamped_reg <= clamped_next;
        end
    end

    assign clamped = clamped_reg;

endmodule

`default_nettype wire

// File: hw/rtl/pskin_merge.sv
// Merge stage: minimum over the eight lanes, slot state, and minimum over the slots.
`default_nettype none

module pskin_merge (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        upd_en,
    input  wire logic [pskin_pkg::CODE_W-1:0] strip_code,
    input  wire logic [pskin_pkg::DIST_W-1:0] lane_val [pskin_pkg::LANE_COUNT],
    output pskin_pkg::best_t                 best
);
    import pskin_pkg::*;

    logic [DIST_W-1:0] slot_min_reg [SLOT_COUNT];
    logic [POS_W-1:0]  slot_pos_reg [SLOT_COUNT];

    logic [DIST_W-1:0] l1_val [4];
    logic [POS_W-1:0]  l1_pos [4];
    logic [DIST_W-1:0] l2_val [2];
    logic [POS_W-1:0]  l2_pos [2];
    logic [DIST_W-1:0] rep_min;
    logic [POS_W-1:0]  rep_pos;

    // Pairwise tree; the right side wins only when strictly smaller, so the
    // earliest position is kept on ties.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (lane_val[2*i+1] < lane_val[2*i]) begin
                l1_val[i] = lane_val[2*i+1];
                l1_pos[i] = POS_W'(2*i+1);
            end else begin
                l1_val[i] = lane_val[2*i];
                l1_pos[i] = POS_W'(2*i);
            end
        end
        for (int i = 0; i < 2; i++) begin
            if (l1_val[2*i+1] < l1_val[2*i]) begin
                l2_val[i] = l1_val[2*i+1];
                l2_pos[i] = l1_pos[2*i+1];
            end else begin
                l2_val[i] = l1_val[2*i];
                l2_pos[i] = l1_pos[2*i];
            end
        end
        if (l2_val[1] < l2_val[0]) begin
            rep_min = l2_val[1];
            rep_pos = l2_pos[1];
        end else begin
            rep_min = l2_val[0];
            rep_pos = l2_pos[0];
        end
    end

    // Slot update; strip codes without a slot leave the slots alone.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_min_reg[i] <= '0;
                slot_pos_reg[i] <= '0;
            end
        end else if (upd_en) begin
            case (strip_code)
                STRIP_SLOT0: begin
                    slot_min_reg[0] <= rep_min;
                    slot_pos_reg[0] <= rep_pos;
                end
                STRIP_SLOT1: begin
                    slot_min_reg[1] <= rep_min;
                    slot_pos_reg[1] <= rep_pos;
                end
                STRIP_SLOT2: begin
                    slot_min_reg[2] <= rep_min;
                    slot_pos_reg[2] <= rep_pos;
                end
                default: begin
                end
            endcase
        end
    end

    // Minimum over the slots; the lowest slot wins on ties.
    always_comb begin
        best.min_dist = slot_min_reg[0];
        best.location = {SLOT_W'(0), slot_pos_reg[0]};
        for (int i = 1; i < SLOT_COUNT; i++) begin
            if (slot_min_reg[i] < best.min_dist) begin
                best.min_dist = slot_min_reg[i];
                best.location = {SLOT_W'(i), slot_pos_reg[i]};
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/pskin_ring.sv
// Averaging ring: window memory, running total and divide by the window length.
`default_nettype none

module pskin_ring #(
    parameter int WINDOW_LEN = pskin_pkg::WINDOW_LEN_DEFAULT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         step,
    input  wire logic [pskin_pkg::DIST_W-1:0] din,
    output logic      [pskin_pkg::DIST_W-1:0] avg
);
    import pskin_pkg::*;

    localparam int IDX_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int TOTAL_W = DIST_W + $clog2(WINDOW_LEN);
    localparam int SHIFT   = TOTAL_W + $clog2(WINDOW_LEN);
    localparam int PROD_W  = 2 * TOTAL_W + 1;
    // Rounded-up reciprocal; exact for every total below 2**TOTAL_W.
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam logic [TOTAL_W:0] RECIP = (TOTAL_W+1)'(RECIP_FULL);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);

    logic [DIST_W-1:0]     mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0] vld_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [TOTAL_W-1:0]    total_reg;
    logic [TOTAL_W-1:0]    total_next;
    logic [DIST_W-1:0]     rd_data_reg;
    logic                  rd_vld_reg;
    logic [DIST_W-1:0]     oldest;
    logic                  bypass;
    logic [PROD_W-1:0]     prod;

    // Next write position, wrapping at the window length.
    always_comb begin
        idx_next = idx_reg;
        if (step) begin
            idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_W'(1);
        end
    end

    // The read port always looks ahead at the next write position; a
    // same-address write is forwarded.
    assign bypass = step && (idx_next == idx_reg);
    assign oldest = rd_vld_reg ? rd_data_reg : '0;
    assign total_next = total_reg - TOTAL_W'(oldest) + TOTAL_W'(din);

    // Control state: position, total and per-entry valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            total_reg  <= '0;
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (step) begin
                idx_reg          <= idx_next;
                total_reg        <= total_next;
                vld_reg[idx_reg] <= 1'b1;
            end
            rd_vld_reg <= bypass ? 1'b1 : vld_reg[idx_next];
        end
    end

    // Window memory with registered read data.
    always_ff @(posedge aclk) begin
        if (step) begin
            mem[idx_reg] <= din;
        end
        rd_data_reg <= bypass ? din : mem[idx_next];
    end

    // Divide by the window length as a multiply by the reciprocal.
    assign prod = PROD_W'(total_reg) * PROD_W'(RECIP);
    assign avg  = prod[SHIFT +: DIST_W];

endmodule

`default_nettype wire

// File: verif/tb_proximity_skin_min_tracker_core.sv
// Self-checking testbench for the proximity skin minimum tracker core.
module tb_proximity_skin_min_tracker_core;

    timeunit 1ns;
    timeprecision 1ps;

    import pskin_pkg::*;

    localparam int RING_LEN     = WINDOW_LEN_DEFAULT;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 12;
    localparam int SHOWN_ERRORS = 10;

    // How the distances of a random report are drawn.
    typedef enum int {
        DIST_FULL,
        DIST_NEAR_CLAMP,
        DIST_TINY,
        DIST_MIXED
    } dist_mix_e;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [DIST_W-1:0] cfg_data  = '0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    in_beat_t          s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    out_beat_t         m_data;

    // Stimulus-side controls.
    bit                idle_en       = 1'b0;
    logic [DIST_W-1:0] clamp_setting = MAX_DISTANCE_RESET;
    int                stall_left    = 0;
    int                quiet_cycles  = 0;
    int                err_count     = 0;

    logic [CODE_W-1:0] slot_codes [SLOT_COUNT] = '{STRIP_SLOT0, STRIP_SLOT1, STRIP_SLOT2};

    // Predicted tracker state.
    logic [DIST_W-1:0] clamp_mm;
    logic [DIST_W-1:0] slot_min_mm [SLOT_COUNT];
    logic [POS_W-1:0]  slot_pos    [SLOT_COUNT];
    logic [DIST_W-1:0] ring_mm     [RING_LEN];
    logic [23:0]       ring_sum;
    int                ring_ptr;
    out_beat_t         pending_results [$];

    proximity_skin_min_tracker_core #(
        .WINDOW_LEN(RING_LEN)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic void reset_tracker_model();
        clamp_mm = MAX_DISTANCE_RESET;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_min_mm[i] = '0;
            slot_pos[i]    = '0;
        end
        for (int i = 0; i < RING_LEN; i++) begin
            ring_mm[i] = '0;
        end
        ring_sum = '0;
        ring_ptr = 0;
    endfunction

    // Updates the predicted state with one report and returns the result beat it causes.
    function automatic out_beat_t next_tracker_result(input in_beat_t rpt);
        logic [DIST_W-1:0] lane [LANE_COUNT];
        logic [DIST_W-1:0] low_mm;
        logic [POS_W-1:0]  low_pos;
        logic [23:0]       quotient;
        int                slot;
        int                win_slot;
        out_beat_t         res;
        lane = '{rpt.dist_0, rpt.dist_7, rpt.dist_1, rpt.dist_6,
                 rpt.dist_2, rpt.dist_5, rpt.dist_3, rpt.dist_4};
        for (int k = 0; k < LANE_COUNT; k++) begin
            if (lane[k] > clamp_mm) lane[k] = clamp_mm;
        end
        case (rpt.strip_code)
            STRIP_SLOT0: slot = 0;
            STRIP_SLOT1: slot = 1;
            STRIP_SLOT2: slot = 2;
            default:     slot = -1;
        endcase

        // Earliest lane wins a tie inside the report.
        if (slot >= 0) begin
            low_mm  = lane[0];
            low_pos = '0;
            for (int k = 1; k < LANE_COUNT; k++) begin
                if (lane[k] < low_mm) begin
                    low_mm  = lane[k];
                    low_pos = POS_W'(k);
                end
            end
            slot_min_mm[slot] = low_mm;
            slot_pos[slot]    = low_pos;
        end

        // Lowest slot wins a tie across the slots.
        win_slot = 0;
        for (int i = 1; i < SLOT_COUNT; i++) begin
            if (slot_min_mm[i] < slot_min_mm[win_slot]) win_slot = i;
        end

        ring_sum          = ring_sum - 24'(ring_mm[ring_ptr]) + 24'(slot_min_mm[win_slot]);
        ring_mm[ring_ptr] = slot_min_mm[win_slot];
        ring_ptr          = (ring_ptr + 1) % RING_LEN;
        quotient          = ring_sum / 24'(RING_LEN);

        res.avg_min_distance = quotient[DIST_W-1:0];
        res.min_location     = {SLOT_W'(win_slot), slot_pos[win_slot]};
        return res;
    endfunction

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= SHOWN_ERRORS) $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Scoreboard: checks result beats, then folds in register writes and new reports.
    always @(posedge aclk) begin : scoreboard
        out_beat_t want;
        if (!aresetn) begin
            reset_tracker_model();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    note_error($sformatf("result beat with nothing expected: avg %0d loc %0d",
                                         m_data.avg_min_distance, m_data.min_location));
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.avg_min_distance !== want.avg_min_distance ||
                        m_data.min_location !== want.min_location) begin
                        note_error($sformatf("expected avg %0d loc %0d, got avg %0d loc %0d",
                                             want.avg_min_distance, want.min_location,
                                             m_data.avg_min_distance, m_data.min_location));
                    end
                end
            end
            if (cfg_valid && cfg_ready) clamp_mm = cfg_data;
            if (s_valid && s_ready) pending_results.push_back(next_tracker_result(s_data));
        end
    end

    // Result-side back-pressure in random bursts.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 12);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic in_beat_t lane_put(input in_beat_t r, input int k,
                                          input logic [DIST_W-1:0] v);
        r[(LANE_COUNT-1-k)*DIST_W +: DIST_W] = v;
        return r;
    endfunction

    function automatic in_beat_t flat_report(input logic [CODE_W-1:0] code,
                                             input logic [DIST_W-1:0] v);
        in_beat_t r;
        r.strip_code = code;
        for (int k = 0; k < LANE_COUNT; k++) r = lane_put(r, k, v);
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] pick_distance(input dist_mix_e mix);
        int v;
        case (mix)
            DIST_FULL: begin
                v = $urandom_range(0, 65535);
            end
            DIST_NEAR_CLAMP: begin
                v = int'(clamp_setting) + int'($urandom_range(0, 8)) - 4;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
            end
            default: begin
                v = $urandom_range(0, 15);
            end
        endcase
        return DIST_W'(v);
    endfunction

    // Mostly slot-owning strips; the rest draws from every code.
    function automatic in_beat_t random_report();
        in_beat_t  r;
        dist_mix_e mix;
        dist_mix_e lane_mix;
        r   = '0;
        mix = dist_mix_e'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 8) r.strip_code = slot_codes[$urandom_range(0, SLOT_COUNT-1)];
        else r.strip_code = CODE_W'($urandom_range(0, 7));
        for (int k = 0; k < LANE_COUNT; k++) begin
            lane_mix = (mix == DIST_MIXED) ? dist_mix_e'($urandom_range(0, 2)) : mix;
            r = lane_put(r, k, pick_distance(lane_mix));
        end
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] random_clamp();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return MAX_DISTANCE_RESET;
            3:       return DIST_W'($urandom_range(0, 64));
            default: return DIST_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Sends one report beat; valid stays high afterwards unless a gap follows.
    task automatic send_report(input in_beat_t rpt);
        int gap;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= rpt;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Writes the clamp once every outstanding result has come back.
    task automatic set_clamp(input logic [DIST_W-1:0] v);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        clamp_setting = v;
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // An ignored strip right after reset sees only zeroed slots and ring.
    task automatic test_power_on_state();
        send_report(flat_report(CODE_W'(5), 16'd300));
    endtask

    // Lane reorder, ignored strips, ties and field extremes.
    task automatic test_lane_order_and_ties();
        in_beat_t r;
        for (int k = 0; k < LANE_COUNT; k++) begin
            r = flat_report(slot_codes[k % SLOT_COUNT], 16'd500);
            send_report(lane_put(r, k, DIST_W'(100 + k)));
        end
        for (int c = 0; c < 2**CODE_W; c++) begin
            if (c != STRIP_SLOT0 && c != STRIP_SLOT1 && c != STRIP_SLOT2) begin
                send_report(lane_put(flat_report(CODE_W'(c), 16'd20), c % LANE_COUNT, 16'd3));
            end
        end
        for (int i = 0; i < SLOT_COUNT; i++) send_report(flat_report(slot_codes[i], 16'd700));
        r = flat_report(STRIP_SLOT1, 16'd900);
        r.dist_3 = 16'd10;
        r.dist_5 = 16'd10;
        send_report(r);
        send_report(flat_report(STRIP_SLOT2, 16'hFFFF));
        send_report(flat_report(STRIP_SLOT0, 16'h0000));
    endtask

    // Clamp at zero, at full scale, at one and back at the reset value.
    task automatic test_clamp_extremes();
        idle_en = 1'b1;
        set_clamp('0);
        repeat (3) send_report(random_report());
        set_clamp('1);
        for (int i = 0; i < SLOT_COUNT; i++) send_report(flat_report(slot_codes[i], 16'hFFFF));
        repeat (2) send_report(random_report());
        set_clamp(16'd1);
        repeat (2) send_report(random_report());
        set_clamp(MAX_DISTANCE_RESET);
        repeat (2) send_report(random_report());
    endtask

    // Random reports with clamp changes; the tail runs without idling.
    task automatic test_random_traffic();
        idle_en = 1'b1;
        for (int n = 0; n < 1400; n++) begin
            if (n == 1280) idle_en = 1'b0;
            if (n % 150 == 149) set_clamp(random_clamp());
            send_report(random_report());
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_power_on_state();
        test_lane_order_and_ties();
        test_clamp_extremes();
        test_random_traffic();

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/pskin_pkg.sv
hw/rtl/pskin_lane.sv
hw/rtl/pskin_merge.sv
hw/rtl/pskin_ring.sv
hw/rtl/proximity_skin_min_tracker_core.sv
verif/tb_proximity_skin_min_tracker_core.sv
